// File: sv/gfla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gfla_pkg;
    typedef enum logic [1:0] {
        MODE_CREATE  = 2'd0,
        MODE_ACQUIRE = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_DESTROY = 2'd3
    } t_mode;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic [6:0] FAVOR_MAX = 7'd100;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] lock_id;
        logic [5:0] requester_id;
        logic [7:0] requester_group;
        logic [6:0] favoritism;
        logic [6:0] rand_percent;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] new_lock_id;
        logic       grant_valid;
        logic [5:0] granted_id;
    } t_rsp;
endpackage
`default_nettype wire

// File: sv/gfla_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gfla_req_if
    import gfla_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gfla_rsp_if
    import gfla_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/group_favoring_lock_arbiter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | payload
// i_req    | in  | mode, lock_id, requester_id, requester_group, favoritism, rand_percent
// o_rsp    | out | status, new_lock_id, grant_valid, granted_id
//
// Acquire, destroy, an empty release and a rejected create are done in one read-and-execute
// pass; a create scans the lock table for a free entry, and a release with waiters searches the
// queue and then shifts it down. All are set by the single read port of the lock and waiter memories.
// Reset clears the lock table entry by entry, with no word accepted until it is done.
// A result word sits in the output register; the next word is taken only once the result has
// gone and the block is back in idle, so a stalled result holds the input off.
module group_favoring_lock_arbiter_core
    import gfla_pkg::*;
#(
    parameter int NUM_LOCKS   = 16,
    parameter int MAX_WAITERS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gfla_req_if.sink   i_req,
    gfla_rsp_if.source o_rsp
);
    localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int WW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int QW = $clog2(MAX_WAITERS + 1);
    localparam int CW = $clog2(NUM_LOCKS + 1);
    // lock entry: active, favour, owner valid, owner id, queue length
    localparam int EW = 1 + 7 + 1 + 6 + QW;

    typedef struct packed {
        logic          active;
        logic [6:0]    favor;
        logic          own_v;
        logic [5:0]    own_id;
        logic [QW-1:0] qlen;
    } t_ent;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_FIND  = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_SHWR  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp;
    logic   r_ov;
    logic [CW-1:0] r_idx;
    logic [QW-1:0] r_wi;
    logic          r_found;
    t_ent          r_ent;

    // lock table memory
    logic          l_we;
    logic [LW-1:0] l_waddr, l_raddr;
    t_ent          l_wdata, l_rdata;
    logic [EW-1:0] l_rraw;
    gfla_ram #(.WIDTH(EW), .DEPTH(NUM_LOCKS)) u_lock (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rraw)
    );
    assign l_rdata = t_ent'(l_rraw);

    // waiter memory, addressed {lock, slot}
    logic             w_we;
    logic [LW+WW-1:0] w_waddr, w_raddr;
    logic [13:0]      w_wdata, w_rdata;
    gfla_ram #(.WIDTH(14), .DEPTH(NUM_LOCKS * MAX_WAITERS)) u_wait (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    logic [LW-1:0] lk;
    logic          lk_ok;
    assign lk    = r_req.lock_id[LW-1:0];
    assign lk_ok = ({28'd0, r_req.lock_id} < 32'(NUM_LOCKS));

    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

    logic [LW-1:0] clr_idx;
    assign clr_idx = r_idx[LW-1:0];

    // queue search: stop at the first group match or at the tail
    logic fnd_hit, fnd_fav, fnd_stop;
    assign fnd_hit  = (w_rdata[13:6] == r_req.requester_group);
    assign fnd_fav  = fnd_hit && (r_req.rand_percent < r_ent.favor);
    assign fnd_stop = fnd_hit || (r_wi + 1'b1 == r_ent.qlen);

    always_comb begin
        n_state = r_state;
        l_we    = 1'b0;
        l_waddr = lk;
        l_wdata = r_ent;
        l_raddr = lk;
        w_we    = 1'b0;
        w_waddr = {lk, r_wi[WW-1:0]};
        w_wdata = {r_req.requester_group, r_req.requester_id};
        w_raddr = {lk, r_wi[WW-1:0]};
        case (r_state)
            S_CLEAR: begin
                l_we    = 1'b1;
                l_waddr = clr_idx;
                l_wdata = '0;
                if (r_idx == CW'(NUM_LOCKS - 1)) n_state = S_IDLE;
            end
            S_IDLE: if (i_req.valid && i_req.ready) n_state = S_RD;
            S_RD: begin
                l_raddr = (r_req.mode == MODE_CREATE) ? clr_idx : lk;
                if (r_req.mode == MODE_CREATE)
                    n_state = (r_req.favoritism > FAVOR_MAX) ? S_OUT : S_SCAN;
                else n_state = lk_ok ? S_EXEC : S_OUT;
            end
            S_SCAN: begin
                l_raddr = LW'(r_idx + 1'b1);
                if (!l_rdata.active) begin
                    l_we    = 1'b1;
                    l_waddr = clr_idx;
                    l_wdata = '{active: 1'b1, favor: r_req.favoritism, own_v: 1'b0,
                                own_id: 6'd0, qlen: '0};
                    n_state = S_OUT;
                end else if (r_idx == CW'(NUM_LOCKS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                if (l_rdata.active) begin
                    case (r_req.mode)
                        MODE_ACQUIRE: begin
                            if (!(l_rdata.own_v && l_rdata.own_id == r_req.requester_id)) begin
                                l_wdata = l_rdata;
                                if (!l_rdata.own_v && l_rdata.qlen == '0) begin
                                    l_we = 1'b1;
                                    l_wdata.own_v  = 1'b1;
                                    l_wdata.own_id = r_req.requester_id;
                                end else if (l_rdata.qlen < QW'(MAX_WAITERS)) begin
                                    l_we = 1'b1;
                                    l_wdata.qlen = l_rdata.qlen + 1'b1;
                                    w_we    = 1'b1;
                                    w_waddr = {lk, l_rdata.qlen[WW-1:0]};
                                end
                            end
                        end
                        MODE_RELEASE: begin
                            if (l_rdata.own_v && l_rdata.own_id == r_req.requester_id) begin
                                if (l_rdata.qlen == '0) begin
                                    l_we = 1'b1;
                                    l_wdata = l_rdata;
                                    l_wdata.own_v  = 1'b0;
                                    l_wdata.own_id = 6'd0;
                                end else begin
                                    w_raddr = {lk, {WW{1'b0}}};
                                    n_state = S_FIND;
                                end
                            end
                        end
                        MODE_DESTROY: begin
                            if (!l_rdata.own_v && l_rdata.qlen == '0) begin
                                l_we = 1'b1;
                                l_wdata = l_rdata;
                                l_wdata.active = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FIND: begin
                // w_rdata is entry r_wi; on stop read the winner, favoured match or head
                w_raddr = {lk, WW'(r_wi + 1'b1)};
                if (fnd_stop) begin
                    w_raddr = {lk, fnd_fav ? r_wi[WW-1:0] : {WW{1'b0}}};
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // read the entry above the gap for move-down
                w_raddr = {lk, WW'(r_wi + 1'b1)};
                n_state = S_SHWR;
                // first pass still sees the old count, later passes the reduced one
                if (r_found ? (r_wi + 1'b1 >= r_ent.qlen) : (r_wi >= r_ent.qlen)) begin
                    l_we = 1'b1;
                    l_wdata = r_ent;
                    if (r_found) begin
                        l_wdata.own_v  = 1'b1;
                        l_wdata.own_id = w_rdata[5:0];
                        l_wdata.qlen   = r_ent.qlen - 1'b1;
                    end
                    n_state = S_OUT;
                end
            end
            S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = {lk, r_wi[WW-1:0]};
                w_wdata = w_rdata;
                n_state = S_SHIFT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (o_rsp.valid && o_rsp.ready) r_ov <= 1'b0;
            case (r_state)
                S_CLEAR: r_idx <= r_idx + 1'b1;
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        r_rsp <= '{status: ST_ERR, new_lock_id: 4'd0,
                                   grant_valid: 1'b0, granted_id: 6'd0};
                        r_idx <= '0;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (!l_rdata.active) begin
                        r_rsp.status      <= ST_OK;
                        r_rsp.new_lock_id <= 4'(r_idx);
                    end
                end
                S_EXEC: begin
                    r_ent   <= l_rdata;
                    r_wi    <= '0;
                    r_found <= 1'b0;
                    if (l_we) begin
                        r_rsp.status <= (w_we) ? ST_WAIT : ST_OK;
                    end
                end
                S_FIND: begin
                    // advance, or hold the winner index on stop
                    r_found <= 1'b1;
                    if (fnd_stop) r_wi <= fnd_fav ? r_wi : '0;
                    else r_wi <= r_wi + 1'b1;
                end
                S_SHIFT: begin
                    if (r_found) begin
                        // winner entry read out now
                        r_rsp <= '{status: ST_OK, new_lock_id: 4'd0,
                                   grant_valid: 1'b1, granted_id: w_rdata[5:0]};
                        r_ent.own_v  <= 1'b1;
                        r_ent.own_id <= w_rdata[5:0];
                        r_ent.qlen   <= r_ent.qlen - 1'b1;
                        r_found      <= 1'b0;
                    end
                end
                S_SHWR: r_wi <= r_wi + 1'b1;
                default: ;
            endcase
            if (n_state == S_OUT && r_state != S_OUT) r_ov <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !r_ov) else $error("word taken while result held");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rsp.ready) |=> $stable(r_rsp)) else $error("result changed while held");
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_rsp.grant_valid) |-> (r_rsp.status == ST_OK)) else $error("grant not ok");
`endif
endmodule
`default_nettype wire

// File: sv/gfla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: dv/group_favoring_lock_arbiter_checker.sv
`timescale 1ns / 1ps
module group_favoring_lock_arbiter_checker
    import gfla_pkg::*;
#(
    parameter int NUM_LOCKS   = 16,
    parameter int MAX_WAITERS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req_data,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp_data,
    output int   o_errors,
    output int   o_pending
);
    logic       lock_on    [NUM_LOCKS];
    logic [6:0] lock_pct   [NUM_LOCKS];
    logic       held       [NUM_LOCKS];
    logic [5:0] holder     [NUM_LOCKS];
    int         wait_cnt   [NUM_LOCKS];
    logic [5:0] wait_id    [NUM_LOCKS][MAX_WAITERS];
    logic [7:0] wait_grp   [NUM_LOCKS][MAX_WAITERS];
    t_rsp       lock_replies[$];

    assign o_pending = lock_replies.size();

    // Work out the reply to one request word and advance the lock table
    function automatic t_rsp arbitrate(t_req rq);
        t_rsp r;
        int   lk;
        int   pick;
        logic [5:0] win;
        r  = '{status: ST_ERR, new_lock_id: 4'd0, grant_valid: 1'b0, granted_id: 6'd0};
        lk = rq.lock_id;
        if (t_mode'(rq.mode) == MODE_CREATE) begin
            if (rq.favoritism > FAVOR_MAX) return r;
            for (int i = 0; i < NUM_LOCKS; i++) begin
                if (!lock_on[i]) begin
                    lock_on[i] = 1'b1; lock_pct[i] = rq.favoritism;
                    held[i] = 1'b0; holder[i] = '0; wait_cnt[i] = 0;
                    r.status = ST_OK; r.new_lock_id = 4'(i);
                    return r;
                end
            end
            return r;
        end
        if (lk >= NUM_LOCKS || !lock_on[lk]) return r;
        case (t_mode'(rq.mode))
            MODE_ACQUIRE: begin
                if (held[lk] && holder[lk] == rq.requester_id) return r;
                if (!held[lk] && wait_cnt[lk] == 0) begin
                    held[lk] = 1'b1; holder[lk] = rq.requester_id; r.status = ST_OK;
                end else if (wait_cnt[lk] < MAX_WAITERS) begin
                    wait_id[lk][wait_cnt[lk]]  = rq.requester_id;
                    wait_grp[lk][wait_cnt[lk]] = rq.requester_group;
                    wait_cnt[lk]++;
                    r.status = ST_WAIT;
                end
            end
            MODE_RELEASE: begin
                if (!held[lk] || holder[lk] != rq.requester_id) return r;
                r.status = ST_OK;
                if (wait_cnt[lk] == 0) begin
                    held[lk] = 1'b0; holder[lk] = '0;
                end else begin
                    pick = 0;
                    for (int i = 0; i < wait_cnt[lk]; i++) begin
                        if (wait_grp[lk][i] == rq.requester_group) begin
                            if (rq.rand_percent < lock_pct[lk]) pick = i;
                            break;
                        end
                    end
                    win = wait_id[lk][pick];
                    for (int i = pick; i + 1 < wait_cnt[lk]; i++) begin
                        wait_id[lk][i]  = wait_id[lk][i+1];
                        wait_grp[lk][i] = wait_grp[lk][i+1];
                    end
                    wait_cnt[lk]--;
                    holder[lk] = win;
                    r.grant_valid = 1'b1; r.granted_id = win;
                end
            end
            default: begin
                if (held[lk] || wait_cnt[lk] != 0) return r;
                lock_on[lk] = 1'b0; r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    // Predict on each accepted request word, compare each reply word
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
            for (int i = 0; i < NUM_LOCKS; i++) begin
                lock_on[i] = 1'b0; lock_pct[i] = '0; held[i] = 1'b0;
                holder[i] = '0; wait_cnt[i] = 0;
            end
        end else begin
            if (i_req_valid && i_req_ready) lock_replies.push_back(arbitrate(i_req_data));
            if (i_rsp_valid && i_rsp_ready) begin
                if (lock_replies.size() == 0) begin
                    $error("reply word with none expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = lock_replies.pop_front();
                    if (exp_r != i_rsp_data) o_errors <= o_errors + 1;
                    if (exp_r.status != i_rsp_data.status)
                        $error("status exp %0d got %0d", exp_r.status, i_rsp_data.status);
                    if (exp_r.new_lock_id != i_rsp_data.new_lock_id)
                        $error("new_lock_id exp %0d got %0d",
                               exp_r.new_lock_id, i_rsp_data.new_lock_id);
                    if (exp_r.grant_valid != i_rsp_data.grant_valid)
                        $error("grant_valid exp %0d got %0d",
                               exp_r.grant_valid, i_rsp_data.grant_valid);
                    if (exp_r.granted_id != i_rsp_data.granted_id)
                        $error("granted_id exp %0d got %0d",
                               exp_r.granted_id, i_rsp_data.granted_id);
                end
            end
        end
    end
endmodule

// File: dv/group_favoring_lock_arbiter_core_tb.sv
`timescale 1ns / 1ps
module group_favoring_lock_arbiter_core_tb;
    import gfla_pkg::*;

    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   sent = 0;
    int   req_gap = 0;
    int   rsp_gap = 0;
    logic [7:0] hot_grp [4];

    gfla_req_if req_ch ();
    gfla_rsp_if rsp_ch ();

    group_favoring_lock_arbiter_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    group_favoring_lock_arbiter_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_ch.valid), .i_req_ready(req_ch.ready), .i_req_data(req_ch.data),
        .i_rsp_valid(rsp_ch.valid), .i_rsp_ready(rsp_ch.ready), .i_rsp_data(rsp_ch.data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
    end

    // Stop with a failure at the limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL group_favoring_lock_arbiter_core");
            $finish;
        end
    end

    // Stall the reply side at random, with long stretches of no stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.valid && rsp_ch.ready)
                rsp_gap <= ((sent / 100) % 3 == 0) ? 0 : $urandom_range(0, 8);
        end
    end

    function automatic t_req make_req(logic [1:0] m, logic [3:0] lk, logic [5:0] id,
                                      logic [7:0] grp, logic [6:0] fav, logic [6:0] rnd);
        t_req r;
        r.mode = m; r.lock_id = lk; r.requester_id = id;
        r.requester_group = grp; r.favoritism = fav; r.rand_percent = rnd;
        return r;
    endfunction

    // Random word, mostly acquires and releases on few locks and few ids
    function automatic t_req random_req();
        int   w;
        logic [1:0] m;
        w = $urandom_range(0, 99);
        m = (w < 10) ? MODE_CREATE : (w < 55) ? MODE_ACQUIRE : (w < 92) ? MODE_RELEASE
                                                                  : MODE_DESTROY;
        if ($urandom_range(0, 9) == 0)
            return make_req(2'($urandom), 4'($urandom), 6'($urandom), 8'($urandom),
                            7'($urandom), 7'($urandom));
        return make_req(m, 4'($urandom_range(0, 5)), 6'($urandom_range(0, 7)),
                        hot_grp[$urandom_range(0, 3)],
                        7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 100)),
                        7'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 127)
                                                       : $urandom_range(0, 99)));
    endfunction

    // Offer one word and wait for it to go; ready is taken between edges
    task automatic send(t_req r);
        logic took;
        req_gap = $urandom_range(0, 8);
        if ((sent / 120) % 3 == 1) req_gap = 0;
        if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (req_gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do begin
            @(negedge i_clk);
            took = req_ch.ready;
            @(posedge i_clk);
        end while (!took);
        sent++;
    endtask

    initial begin
        hot_grp[0] = 8'h00; hot_grp[1] = 8'hff; hot_grp[2] = 8'h5a; hot_grp[3] = 8'ha5;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad favoritism, extremes, re-entry, favoured hand-over, busy destroy
        send(make_req(MODE_CREATE, 0, 0, 0, 7'd101, 0));
        send(make_req(MODE_CREATE, 0, 0, 0, 7'd127, 0));
        send(make_req(MODE_ACQUIRE, 4'd15, 0, 0, 0, 0));
        send(make_req(MODE_CREATE, 0, 0, 0, 7'd100, 0));
        send(make_req(MODE_CREATE, 0, 0, 0, 7'd0, 0));
        send(make_req(MODE_ACQUIRE, 0, 6'd63, 8'hff, 0, 0));
        send(make_req(MODE_ACQUIRE, 0, 6'd63, 8'hff, 0, 0));
        send(make_req(MODE_ACQUIRE, 0, 6'd1, 8'h00, 0, 0));
        send(make_req(MODE_ACQUIRE, 0, 6'd2, 8'hff, 0, 0));
        send(make_req(MODE_ACQUIRE, 0, 6'd1, 8'h00, 0, 0));
        send(make_req(MODE_DESTROY, 0, 0, 0, 0, 0));
        send(make_req(MODE_RELEASE, 0, 6'd5, 8'hff, 0, 0));
        send(make_req(MODE_RELEASE, 0, 6'd63, 8'hff, 0, 7'd127));
        send(make_req(MODE_RELEASE, 0, 6'd1, 8'h00, 0, 7'd99));
        send(make_req(MODE_RELEASE, 0, 6'd2, 8'h00, 0, 7'd0));
        send(make_req(MODE_RELEASE, 0, 6'd1, 8'h00, 0, 0));
        send(make_req(MODE_RELEASE, 1, 6'd0, 8'h00, 0, 0));
        send(make_req(MODE_DESTROY, 0, 0, 0, 0, 0));
        send(make_req(MODE_DESTROY, 4'd9, 0, 0, 0, 0));
        // Fill the table, then overflow one queue
        repeat (17) send(make_req(MODE_CREATE, 0, 0, 0, 7'd50, 0));
        for (int i = 0; i < 18; i++)
            send(make_req(MODE_ACQUIRE, 4'd3, 6'(i + 10), 8'(i), 0, 0));
        for (int i = 0; i < 16; i++)
            send(make_req(MODE_RELEASE, 4'd3, 6'(i + 10), 8'(i + 12), 0, 7'(i * 3)));

        // Random
        for (int n = 0; n < 850; n++) send(random_req());
        req_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS group_favoring_lock_arbiter_core");
        else
            $display("FAIL group_favoring_lock_arbiter_core");
        $finish;
    end
endmodule

// File: sim.f
sv/gfla_pkg.sv
sv/gfla_if.sv
sv/gfla_ram.sv
sv/group_favoring_lock_arbiter_core.sv
dv/group_favoring_lock_arbiter_checker.sv
dv/group_favoring_lock_arbiter_core_tb.sv
